>>> rtl/core/aabb_collision_response_macros.svh
// Assertion macros for the collision response block
`ifndef AABB_COLLISION_RESPONSE_MACROS_SVH
`define AABB_COLLISION_RESPONSE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AABB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define AABB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define AABB_ASSERT_IMPL(label, ante, cons, msg)
`define AABB_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> rtl/core/aabb_pkg.sv
// Shared constants for the collision response block
`timescale 1ns / 1ps
package aabb_pkg;
  localparam int COORD_BITS_DEF    = 24;
  localparam int VEL_FRAC_BITS_DEF = 16;
  localparam int VEL_BITS          = 32;
  localparam int RATIO_FRAC        = 16;
  localparam int CFG_BITS          = 16;

  localparam logic [CFG_BITS-1:0] RESTITUTION_RST = 16'd7864;
  localparam logic [CFG_BITS-1:0] STICKY_RST      = 16'd262;
  localparam logic [CFG_BITS-1:0] CORNER_TOL_RST  = 16'd6554;

  localparam logic [1:0] CFG_RESTITUTION = 2'd0;
  localparam logic [1:0] CFG_STICKY      = 2'd1;
  localparam logic [1:0] CFG_CORNER_TOL  = 2'd2;

  localparam logic [1:0] KIND_CORNER = 2'd0;
  localparam logic [1:0] KIND_SIDE   = 2'd1;
  localparam logic [1:0] KIND_TOP    = 2'd2;
endpackage

>>> rtl/core/aabb_collision_response.sv
// An accepted item passes through the input register, the divider stages, stage A and stage B to its result.
// Throughput: one item per cycle; the whole pipeline holds while a result is stalled.
// Each axis uses a restoring divider that yields one quotient bit per stage.
// Reset (rst, synchronous) empties the pipeline and loads the register defaults.
// Configuration writes are taken in every cycle.
`timescale 1ns / 1ps
`include "aabb_collision_response_macros.svh"
module aabb_collision_response #(
  parameter int COORD_BITS    = aabb_pkg::COORD_BITS_DEF,
  parameter int VEL_FRAC_BITS = aabb_pkg::VEL_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [1:0]                            cfg_index,
  input  logic [aabb_pkg::CFG_BITS-1:0]         cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [COORD_BITS-1:0]          actor_left,
  input  logic signed [COORD_BITS-1:0]          actor_top,
  input  logic [COORD_BITS-2:0]                 actor_width,
  input  logic [COORD_BITS-2:0]                 actor_height,
  input  logic signed [COORD_BITS-1:0]          block_left,
  input  logic signed [COORD_BITS-1:0]          block_top,
  input  logic [COORD_BITS-2:0]                 block_width,
  input  logic [COORD_BITS-2:0]                 block_height,
  input  logic signed [aabb_pkg::VEL_BITS-1:0]  velocity_x,
  input  logic signed [aabb_pkg::VEL_BITS-1:0]  velocity_y,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [1:0]                            contact_kind,
  output logic                                  set_x,
  output logic signed [COORD_BITS-1:0]          new_x,
  output logic                                  set_y,
  output logic signed [COORD_BITS-1:0]          new_y,
  output logic signed [aabb_pkg::VEL_BITS-1:0]  new_velocity_x,
  output logic signed [aabb_pkg::VEL_BITS-1:0]  new_velocity_y
);
  localparam int CB = COORD_BITS;
  localparam int VB = aabb_pkg::VEL_BITS;
  localparam int CW = aabb_pkg::CFG_BITS;
  localparam int NW = CB + 3;
  localparam int AW = CB + 2;
  localparam int SW = CB + 1;
  localparam int QW = AW + aabb_pkg::RATIO_FRAC - 1;
  localparam int PW = VB + CW;
  localparam int TW = 2 * VB;

  typedef struct packed {
    logic [CB-2:0]        rem_x;
    logic [CB-2:0]        rem_y;
    logic [CB-2:0]        div_x;
    logic [CB-2:0]        div_y;
    logic [QW-1:0]        dq_x;
    logic [QW-1:0]        dq_y;
    logic signed [CB-1:0] snap_x;
    logic signed [CB-1:0] snap_y;
    logic signed [VB-1:0] vx;
    logic signed [VB-1:0] vy;
  } div_stage_t;

  // Configuration registers
  logic [CW-1:0] restitution;
  logic [CW-1:0] stick_limit;
  logic [CW-1:0] corner_tolerance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      restitution      <= aabb_pkg::RESTITUTION_RST;
      stick_limit      <= aabb_pkg::STICKY_RST;
      corner_tolerance <= aabb_pkg::CORNER_TOL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        aabb_pkg::CFG_RESTITUTION: restitution      <= cfg_data;
        aabb_pkg::CFG_STICKY:      stick_limit      <= cfg_data;
        aabb_pkg::CFG_CORNER_TOL:  corner_tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  // Global advance: hold everything while the result waits
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Front end: centre offsets, magnitudes, snapped edges
  logic signed [NW-1:0] nx, ny;
  logic [AW-1:0]        ax, ay;
  logic signed [SW-1:0] sx_raw, sy_raw;
  logic signed [CB-1:0] sx_sat, sy_sat;
  logic signed [CB-1:0] cmax, cmin;

  assign cmax = {1'b0, {(CB-1){1'b1}}};
  assign cmin = {1'b1, {(CB-1){1'b0}}};

  always_comb begin
    nx = ((NW'(block_left) - NW'(actor_left)) <<< 1)
         + NW'({1'b0, block_width}) - NW'({1'b0, actor_width});
    ny = ((NW'(block_top) - NW'(actor_top)) <<< 1)
         + NW'({1'b0, block_height}) - NW'({1'b0, actor_height});
    ax = nx[NW-1] ? AW'(-nx) : AW'(nx);
    ay = ny[NW-1] ? AW'(-ny) : AW'(ny);
    sx_raw = nx[NW-1] ? SW'(block_left) + SW'({1'b0, block_width})
                      : SW'(block_left) - SW'({1'b0, actor_width});
    sy_raw = ny[NW-1] ? SW'(block_top) + SW'({1'b0, block_height})
                      : SW'(block_top) - SW'({1'b0, actor_height});
    if (sx_raw[SW-1] != sx_raw[SW-2]) sx_sat = sx_raw[SW-1] ? cmin : cmax;
    else                              sx_sat = sx_raw[CB-1:0];
    if (sy_raw[SW-1] != sy_raw[SW-2]) sy_sat = sy_raw[SW-1] ? cmin : cmax;
    else                              sy_sat = sy_raw[CB-1:0];
  end

  // Divider pipeline: one quotient bit per stage for each axis
  div_stage_t pipe [0:QW];
  logic       pv   [0:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      pv[0] <= 1'b0;
    end else if (adv) begin
      pv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe[0].rem_x  <= '0;
      pipe[0].rem_y  <= '0;
      pipe[0].div_x  <= (block_width == '0) ? (CB-1)'(1) : block_width;
      pipe[0].div_y  <= (block_height == '0) ? (CB-1)'(1) : block_height;
      pipe[0].dq_x   <= {ax, {(aabb_pkg::RATIO_FRAC-1){1'b0}}};
      pipe[0].dq_y   <= {ay, {(aabb_pkg::RATIO_FRAC-1){1'b0}}};
      pipe[0].snap_x <= sx_sat;
      pipe[0].snap_y <= sy_sat;
      pipe[0].vx     <= velocity_x;
      pipe[0].vy     <= velocity_y;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [CB-1:0] tx, ty;
    logic          gx, gy;
    always_comb begin
      tx = {pipe[k].rem_x, pipe[k].dq_x[QW-1]};
      ty = {pipe[k].rem_y, pipe[k].dq_y[QW-1]};
      gx = tx >= {1'b0, pipe[k].div_x};
      gy = ty >= {1'b0, pipe[k].div_y};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        pv[k+1] <= 1'b0;
      end else if (adv) begin
        pv[k+1] <= pv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        pipe[k+1].div_x  <= pipe[k].div_x;
        pipe[k+1].div_y  <= pipe[k].div_y;
        pipe[k+1].snap_x <= pipe[k].snap_x;
        pipe[k+1].snap_y <= pipe[k].snap_y;
        pipe[k+1].vx     <= pipe[k].vx;
        pipe[k+1].vy     <= pipe[k].vy;
        pipe[k+1].rem_x  <= gx ? (CB-1)'(tx - {1'b0, pipe[k].div_x}) : tx[CB-2:0];
        pipe[k+1].rem_y  <= gy ? (CB-1)'(ty - {1'b0, pipe[k].div_y}) : ty[CB-2:0];
        pipe[k+1].dq_x   <= {pipe[k].dq_x[QW-2:0], gx};
        pipe[k+1].dq_y   <= {pipe[k].dq_y[QW-2:0], gy};
      end
    end
  end

  // Stage A: classify contact, scale velocity magnitudes
  logic [QW-1:0]        mx, my, diff;
  logic [1:0]           kind_c;
  logic [VB-1:0]        vax, vay;
  logic                 a_valid;
  logic [1:0]           a_kind;
  logic [PW-1:0]        a_prod_x, a_prod_y;
  logic signed [CB-1:0] a_snap_x, a_snap_y;
  logic signed [VB-1:0] a_vx, a_vy;

  always_comb begin
    mx   = pipe[QW].dq_x;
    my   = pipe[QW].dq_y;
    diff = (mx > my) ? mx - my : my - mx;
    if (diff < QW'(corner_tolerance)) kind_c = aabb_pkg::KIND_CORNER;
    else if (mx > my)                 kind_c = aabb_pkg::KIND_SIDE;
    else                              kind_c = aabb_pkg::KIND_TOP;
    vax = pipe[QW].vx[VB-1] ? VB'(-pipe[QW].vx) : VB'(pipe[QW].vx);
    vay = pipe[QW].vy[VB-1] ? VB'(-pipe[QW].vy) : VB'(pipe[QW].vy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= pv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_kind   <= kind_c;
      a_prod_x <= PW'(vax) * PW'(restitution);
      a_prod_y <= PW'(vay) * PW'(restitution);
      a_snap_x <= pipe[QW].snap_x;
      a_snap_y <= pipe[QW].snap_y;
      a_vx     <= pipe[QW].vx;
      a_vy     <= pipe[QW].vy;
    end
  end

  // Stage B: round, apply sticky threshold, select result
  logic [PW-1:0]        rnd_x, rnd_y;
  logic [VB-1:0]        mag_x, mag_y;
  logic [TW-1:0]        thr_w;
  logic signed [VB-1:0] rx, ry;

  always_comb begin
    rnd_x = a_prod_x + PW'(32768);
    rnd_y = a_prod_y + PW'(32768);
    mag_x = rnd_x[PW-1:CW];
    mag_y = rnd_y[PW-1:CW];
    thr_w = TW'(stick_limit) << VEL_FRAC_BITS;
    if ({TW'(mag_x)} << 16 < thr_w) rx = '0;
    else rx = a_vx[VB-1] ? $signed(mag_x) : -$signed(mag_x);
    if ({TW'(mag_y)} << 16 < thr_w) ry = '0;
    else ry = a_vy[VB-1] ? $signed(mag_y) : -$signed(mag_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      contact_kind <= a_kind;
      case (a_kind)
        aabb_pkg::KIND_CORNER: begin
          set_x <= 1'b1; new_x <= a_snap_x;
          set_y <= 1'b1; new_y <= a_snap_y;
          new_velocity_x <= rx; new_velocity_y <= a_vy;
        end
        aabb_pkg::KIND_SIDE: begin
          set_x <= 1'b1; new_x <= a_snap_x;
          set_y <= 1'b0; new_y <= '0;
          new_velocity_x <= rx; new_velocity_y <= a_vy;
        end
        default: begin
          set_x <= 1'b0; new_x <= '0;
          set_y <= 1'b1; new_y <= a_snap_y;
          new_velocity_x <= a_vx; new_velocity_y <= ry;
        end
      endcase
    end
  end

  // Checks
  `AABB_ASSERT_IMPL(a_corner_sets, out_valid && contact_kind == aabb_pkg::KIND_CORNER, set_x && set_y, "corner: both set")
  `AABB_ASSERT_IMPL(a_top_sets, out_valid && contact_kind == aabb_pkg::KIND_TOP, !set_x && set_y, "top: y only")
  `AABB_ASSERT_IMPL(a_x_zero, out_valid && !set_x, new_x == '0, "unreplaced x not zero")
  `AABB_ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall, "input held without cause")
endmodule
